/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define RTCEP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define RTCEP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rtcep_pkg.sv */
`default_nettype none

package rtcep_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);

    localparam logic [13:0] PivotYearReset = 14'd2021;
    localparam logic [13:0] PivotBaseReset = 14'd2000;
    localparam logic [13:0] YearMax        = 14'd9999;

    // Julian day of 1970-01-01 plus the 32045 bias of the day formula
    localparam int JdOffset   = 2440588 + 32045;
    localparam int DaySeconds = 60 * 60 * 24;
    localparam int YearBias   = 4799;

    typedef enum logic [1:0] {
        CFG_BINARY_MODE     = 2'd0,
        CFG_HOUR_24_MODE    = 2'd1,
        CFG_CENTURY_PRESENT = 2'd2,
        CFG_PIVOT_YEAR      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        binary_mode;
        logic        hour_24_mode;
        logic        century_present;
        logic [13:0] pivot_year;
        logic [13:0] pivot_base;  // pivot_year rounded down to its century
    } cfg_t;

    // One classified snapshot, as handed from the front end to the back end
    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [4:0]  hour;
        logic [7:0]  day;
        logic [4:0]  mon_idx;  // March-based month index
        logic [4:0]  year_adj; // y = year + YearBias + year_adj
        logic [13:0] year;
    } item_t;

endpackage

`default_nettype wire

/* sv/rtcep_front.sv */
`default_nettype none

module rtcep_front
    import rtcep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] second_raw,
    input  logic [7:0] minute_raw,
    input  logic [7:0] hour_raw,
    input  logic [7:0] day_raw,
    input  logic [7:0] month_raw,
    input  logic [7:0] year_raw,
    input  logic [7:0] century_raw,
    output logic       q_valid,
    input  logic       q_stall,
    output item_t      q_item
);

    function automatic logic [7:0] decode(input logic [7:0] v, input logic bin);
        logic [7:0] bcd;
        bcd = {4'd0, v[3:0]} + {4'd0, v[7:4]} * 8'd10;
        return bin ? v : bcd;
    endfunction

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic        load;

    logic [7:0]  mon;
    logic [7:0]  yr2;
    logic [7:0]  cen;
    logic [7:0]  hr;
    logic [14:0] yr_cen;
    logic [14:0] yr_win;
    logic [14:0] yr_sel;
    logic [7:0]  mon_ex;
    logic [15:0] q_prod;
    logic [4:0]  mon_q;
    logic [7:0]  mon_r;

    assign load     = !valid_reg || !q_stall;
    assign in_stall = !load;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb
    begin
        mon = decode(month_raw, cfg.binary_mode);
        yr2 = decode(year_raw, cfg.binary_mode);
        cen = decode(century_raw, cfg.binary_mode);

        // PM flag is never part of the hour value
        if (cfg.binary_mode)
        begin
            hr = {1'b0, hour_raw[6:0]};
        end
        else
        begin
            hr = {4'd0, hour_raw[3:0]} + {5'd0, hour_raw[6:4]} * 8'd10;
        end
        if (!cfg.hour_24_mode)
        begin
            if (hr == 8'd12)
            begin
                hr = 8'd0;
            end
            if (hour_raw[7])
            begin
                hr = hr + 8'd12;
            end
        end
        // hour is at most 139 here: five conditional subtracts reduce it mod 24
        for (int i = 0; i < 5; i++)
        begin
            if (hr >= 8'd24)
            begin
                hr = hr - 8'd24;
            end
        end

        yr_cen = {7'd0, yr2} + {7'd0, cen} * 15'd100;
        yr_win = {1'b0, cfg.pivot_base} + {7'd0, yr2};
        if (yr_win < {1'b0, cfg.pivot_year})
        begin
            yr_win = yr_win + 15'd100;
        end
        yr_sel = cfg.century_present ? yr_cen : yr_win;
        if (yr_sel > {1'b0, YearMax})
        begin
            yr_sel = {1'b0, YearMax};
        end

        // (14 - mon) / 12 truncates toward zero; months above 14 give a negative a
        mon_ex = mon - 8'd14;
        q_prod = {8'd0, mon_ex} * 16'd171;  // mon_ex / 12 for mon_ex <= 241
        mon_q  = q_prod[15:11];
        mon_r  = mon_ex - {3'd0, mon_q} * 8'd12;

        item_next.sec  = decode(second_raw, cfg.binary_mode);
        item_next.min  = decode(minute_raw, cfg.binary_mode);
        item_next.hour = hr[4:0];
        item_next.day  = decode(day_raw, cfg.binary_mode);
        item_next.year = yr_sel[13:0];
        if (mon <= 8'd2)
        begin
            item_next.mon_idx  = 5'(mon + 8'd9);
            item_next.year_adj = 5'd0;
        end
        else if (mon <= 8'd14)
        begin
            item_next.mon_idx  = 5'(mon - 8'd3);
            item_next.year_adj = 5'd1;
        end
        else
        begin
            item_next.mon_idx  = 5'(mon_r + 8'd11);
            item_next.year_adj = mon_q + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* sv/rtcep_fifo.sv */
`default_nettype none

module rtcep_fifo
    import rtcep_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_stall,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_stall,
    output item_t rd_item
);

    item_t                 mem [FifoDepth];
    logic [FifoPtrW-1:0]   wr_ptr_reg;
    logic [FifoPtrW-1:0]   rd_ptr_reg;
    logic [FifoPtrW:0]     count_reg;
    logic [FifoPtrW:0]     count_next;
    logic                  push;
    logic                  pop;

    assign wr_stall = (count_reg == (FifoPtrW + 1)'(FifoDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

/* sv/rtcep_back.sv */
`default_nettype none

module rtcep_back
    import rtcep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  item_t       in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] epoch_seconds,
    output logic [13:0] full_year,
    output logic [4:0]  hour_24
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1: shifted year, month term, time of day
    logic [14:0] y1_reg, y1_next;
    logic [9:0]  f1_reg, f1_next;
    logic [16:0] tod1_reg, tod1_next;
    logic [7:0]  day1_reg;
    logic [13:0] year1_reg;
    logic [4:0]  hour1_reg;
    logic [11:0] mterm;
    logic [25:0] mprod;

    // stage 2: year products
    logic [22:0] y365_2_reg;
    logic [7:0]  yq2_reg;
    logic [12:0] y4_2_reg;
    logic [27:0] yprod;
    logic [7:0]  day2_reg;
    logic [9:0]  f2_reg;
    logic [16:0] tod2_reg;
    logic [13:0] year2_reg;
    logic [4:0]  hour2_reg;

    // stage 3: day number relative to 1970-01-01
    logic signed [23:0] jd3_reg;
    logic [24:0]        jd_pos;
    logic [24:0]        jd_neg;
    logic [24:0]        jd_diff;
    logic [16:0]        tod3_reg;
    logic [13:0]        year3_reg;
    logic [4:0]         hour3_reg;

    // stage 4: day seconds
    logic signed [41:0] prod4_reg;
    logic signed [41:0] prod4_next;
    logic [16:0]        tod4_reg;
    logic [13:0]        year4_reg;
    logic [4:0]         hour4_reg;

    // stage 5: output register
    logic [63:0] epoch5_reg;
    logic [13:0] year5_reg;
    logic [4:0]  hour5_reg;

    assign en5      = !v5_reg || !out_stall;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign out_valid     = v5_reg;
    assign epoch_seconds = epoch5_reg;
    assign full_year     = year5_reg;
    assign hour_24       = hour5_reg;

    always_comb
    begin
        y1_next   = {1'b0, in_item.year} + 15'(YearBias) + {10'd0, in_item.year_adj};
        mterm     = {7'd0, in_item.mon_idx} * 12'd153 + 12'd2;
        mprod     = {14'd0, mterm} * 26'd13108;  // divide by 5
        f1_next   = mprod[25:16];
        tod1_next = {12'd0, in_item.hour} * 17'd3600 + {9'd0, in_item.min} * 17'd60
                  + {9'd0, in_item.sec};

        yprod = {13'd0, y1_reg} * 28'd5243;  // divide by 100 for y below 25600

        jd_pos  = {2'd0, y365_2_reg} + {12'd0, y4_2_reg} + {19'd0, yq2_reg[7:2]}
                + {17'd0, day2_reg} + {15'd0, f2_reg};
        jd_neg  = {17'd0, yq2_reg} + 25'(JdOffset);
        jd_diff = jd_pos - jd_neg;

        prod4_next = jd3_reg * $signed(18'(DaySeconds));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            y1_reg    <= y1_next;
            f1_reg    <= f1_next;
            tod1_reg  <= tod1_next;
            day1_reg  <= in_item.day;
            year1_reg <= in_item.year;
            hour1_reg <= in_item.hour;
        end
        if (en2)
        begin
            y365_2_reg <= {8'd0, y1_reg} * 23'd365;
            yq2_reg    <= yprod[26:19];
            y4_2_reg   <= y1_reg[14:2];
            day2_reg   <= day1_reg;
            f2_reg     <= f1_reg;
            tod2_reg   <= tod1_reg;
            year2_reg  <= year1_reg;
            hour2_reg  <= hour1_reg;
        end
        if (en3)
        begin
            jd3_reg   <= $signed(jd_diff[23:0]);
            tod3_reg  <= tod2_reg;
            year3_reg <= year2_reg;
            hour3_reg <= hour2_reg;
        end
        if (en4)
        begin
            prod4_reg <= prod4_next;
            tod4_reg  <= tod3_reg;
            year4_reg <= year3_reg;
            hour4_reg <= hour3_reg;
        end
        if (en5)
        begin
            // sign extension makes dates before 1970 wrap modulo 2^64
            epoch5_reg <= {{22{prod4_reg[41]}}, prod4_reg} + {47'd0, tod4_reg};
            year5_reg  <= year4_reg;
            hour5_reg  <= hour4_reg;
        end
    end

endmodule

`default_nettype wire

/* sv/rtc_fields_to_unix_epoch.sv */
// Path: an accepted input transaction passes the front register, the queue, then five
//   back-end stages ending in the output register, where out_valid rises.
// Throughput: one transaction per cycle while out_stall is low; the four-entry queue lets
//   the front keep taking snapshots while the back end is stalled.
// Reset: asynchronous, active low; clears the queue and all stage valids and sets the
//   configuration to BCD, 12-hour, pivot window with pivot_year 2021.
`default_nettype none

module rtc_fields_to_unix_epoch
    import rtcep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  second_raw,
    input  logic [7:0]  minute_raw,
    input  logic [7:0]  hour_raw,
    input  logic [7:0]  day_raw,
    input  logic [7:0]  month_raw,
    input  logic [7:0]  year_raw,
    input  logic [7:0]  century_raw,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] epoch_seconds,
    output logic [13:0] full_year,
    output logic [4:0]  hour_24
);

    // year rounded down to its century: p / 100 by reciprocal, exact for 14 bits
    function automatic logic [13:0] century_base(input logic [13:0] p);
        logic [26:0] prod;
        logic [7:0]  q;
        prod = {13'd0, p} * 27'd5243;
        q    = prod[26:19];
        return 14'({6'd0, q} * 14'd100);
    endfunction

    cfg_t  cfg_reg;
    logic  fq_valid;
    logic  fq_stall;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_stall;
    item_t qb_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.binary_mode     <= 1'b0;
            cfg_reg.hour_24_mode    <= 1'b0;
            cfg_reg.century_present <= 1'b0;
            cfg_reg.pivot_year      <= PivotYearReset;
            cfg_reg.pivot_base      <= PivotBaseReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BINARY_MODE:     cfg_reg.binary_mode     <= cfg_data[0];
                CFG_HOUR_24_MODE:    cfg_reg.hour_24_mode    <= cfg_data[0];
                CFG_CENTURY_PRESENT: cfg_reg.century_present <= cfg_data[0];
                CFG_PIVOT_YEAR:
                begin
                    cfg_reg.pivot_year <= cfg_data;
                    cfg_reg.pivot_base <= century_base(cfg_data);
                end
            endcase
        end
    end

    rtcep_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .second_raw  (second_raw),
        .minute_raw  (minute_raw),
        .hour_raw    (hour_raw),
        .day_raw     (day_raw),
        .month_raw   (month_raw),
        .year_raw    (year_raw),
        .century_raw (century_raw),
        .q_valid     (fq_valid),
        .q_stall     (fq_stall),
        .q_item      (fq_item)
    );

    rtcep_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_item  (qb_item)
    );

    rtcep_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_stall      (qb_stall),
        .in_item       (qb_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_seconds (epoch_seconds),
        .full_year     (full_year),
        .hour_24       (hour_24)
    );

endmodule

`default_nettype wire

/* sv/rtcep_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module rtcep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] epoch_seconds,
    input logic [13:0] full_year,
    input logic [4:0]  hour_24
);

    `RTCEP_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    `RTCEP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(epoch_seconds) && $stable(full_year) && $stable(hour_24), "stalled result changed")

    `RTCEP_ASSERT(a_year_sat, out_valid |-> full_year <= 14'd9999, "full_year above 9999")

    `RTCEP_ASSERT(a_hour_range, out_valid |-> hour_24 <= 5'd23, "hour_24 above 23")

endmodule

bind rtc_fields_to_unix_epoch rtcep_checker u_rtcep_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds),
    .full_year     (full_year),
    .hour_24       (hour_24)
);

`default_nettype wire
